// ===== design/flcp_pkg.sv =====
// Shared constants, command codes and store-port types for the line and circle plotter.
package flcp_pkg;

   localparam int SCREEN_WIDTH_DEF = 128;
   localparam int PAGE_COUNT_DEF   = 8;

   localparam logic [2:0] CMD_PIXEL  = 3'd0;
   localparam logic [2:0] CMD_LINE   = 3'd1;
   localparam logic [2:0] CMD_CIRCLE = 3'd2;
   localparam logic [2:0] CMD_CLEAR  = 3'd3;
   localparam logic [2:0] CMD_READ   = 3'd4;

   // Pixel request from the sequencer to the store unit.
   typedef struct packed {
      logic       valid;
      logic       paint;
      logic       force_zero;
      logic [9:0] x;
      logic [9:0] y;
   } pix_req_type;

   typedef struct packed {
      logic busy;
      logic rd_valid;
   } pix_sts_type;

endpackage

// ===== design/framebuffer_line_circle_plotter.sv =====
// Top level of the one-bit frame-buffer line and circle plotter.
// One command is taken when start is high and busy is low; exactly one result
// appears later with rsp_valid high for one cycle. The receiver cannot stall and
// must take each result in its strobe cycle. Each on-screen pixel that is plotted
// is one read-modify-write of the frame memory, which has one read and one write
// port. After reset the memory is swept to zero, which holds busy until the sweep
// is done.
module framebuffer_line_circle_plotter #(
   parameter int SCREEN_WIDTH = flcp_pkg::SCREEN_WIDTH_DEF,
   parameter int PAGE_COUNT   = flcp_pkg::PAGE_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_cmd,
   input  logic [6:0] req_start_x,
   input  logic [5:0] req_start_y,
   input  logic [6:0] req_end_x,
   input  logic [5:0] req_end_y,
   input  logic [5:0] req_radius,
   input  logic       req_paint,
   output logic       rsp_valid,
   output logic [7:0] rsp_read_data,
   output logic       rsp_done_res
);
   import flcp_pkg::*;

   pix_req_type pix_req;
   pix_sts_type sts;
   logic        clear_req, read_req;
   logic [7:0]  rd_data;

   flcp_seq u_seq (
      .clock, .reset, .start, .busy,
      .cmd(req_cmd), .sx(req_start_x), .sy(req_start_y),
      .ex(req_end_x), .ey(req_end_y), .radius(req_radius), .paint(req_paint),
      .pix_req, .clear_req, .read_req, .sts, .rd_data,
      .rsp_valid, .rsp_read_data, .rsp_done_res
   );

   flcp_store #(.SCREEN_WIDTH(SCREEN_WIDTH), .PAGE_COUNT(PAGE_COUNT)) u_store (
      .clock, .reset, .pix_req, .clear_req, .read_req, .sts, .rd_data
   );
endmodule

// ===== design/flcp_store.sv =====
// Frame store with a read-modify-write pixel port, a clearing sweep and a byte read.
module flcp_store #(
   parameter int SCREEN_WIDTH = flcp_pkg::SCREEN_WIDTH_DEF,
   parameter int PAGE_COUNT   = flcp_pkg::PAGE_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  flcp_pkg::pix_req_type pix_req,
   input  logic                  clear_req,
   input  logic                  read_req,
   output flcp_pkg::pix_sts_type sts,
   output logic [7:0]            rd_data
);
   import flcp_pkg::*;

   localparam int DEPTH = SCREEN_WIDTH * PAGE_COUNT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HEIGHT = PAGE_COUNT * 8;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MOD   = 2'd1;
   localparam logic [1:0] ST_CLEAR = 2'd2;

   logic [7:0]    mem [DEPTH];
   logic [7:0]    q_ff;
   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [7:0]    mask_ff, mask_in;
   logic          paint_ff, paint_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          zero_ff, zero_in;
   logic          on_screen;
   logic [AW-1:0] req_addr;
   logic          we;
   logic [AW-1:0] waddr;
   logic [7:0]    wdata;

   assign on_screen = (pix_req.x < 10'(SCREEN_WIDTH)) && (pix_req.y < 10'(HEIGHT));
   assign req_addr  = AW'(32'(pix_req.y[9:3]) * SCREEN_WIDTH + 32'(pix_req.x));

   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      sweep_in   = sweep_ff;
      mask_in    = mask_ff;
      paint_in   = paint_ff;
      rd_pend_in = 1'b0;
      zero_in    = zero_ff;
      we         = 1'b0;
      waddr      = addr_ff;
      wdata      = 8'd0;
      case (state_ff)
         ST_IDLE: begin
            if (clear_req) begin
               state_in = ST_CLEAR;
               sweep_in = '0;
            end else if (pix_req.valid) begin
               addr_in    = req_addr;
               mask_in    = 8'(1) << pix_req.y[2:0];
               paint_in   = pix_req.paint;
               zero_in    = pix_req.force_zero || !on_screen;
               rd_pend_in = read_req;
               if (on_screen && !read_req) state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            we       = 1'b1;
            wdata    = paint_ff ? (q_ff | mask_ff) : (q_ff & ~mask_ff);
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            we    = 1'b1;
            waddr = sweep_ff;
            sweep_in = sweep_ff + AW'(1);
            if (32'(sweep_ff) == DEPTH - 1) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      q_ff <= mem[req_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         sweep_ff   <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sweep_ff   <= sweep_in;
         rd_pend_ff <= rd_pend_in;
      end
      addr_ff  <= addr_in;
      mask_ff  <= mask_in;
      paint_ff <= paint_in;
      zero_ff  <= zero_in;
   end

   assign sts.busy     = (state_ff != ST_IDLE);
   assign sts.rd_valid = rd_pend_ff;
   assign rd_data      = zero_ff ? 8'd0 : q_ff;

`ifndef NO_ASSERTIONS
   a_mod_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOD |=> state_ff == ST_IDLE) else $error("modify not single");
   a_rd_idle: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> state_ff == ST_IDLE) else $error("read while busy");
   a_clr_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR && 32'(sweep_ff) == DEPTH - 1 |=> state_ff == ST_IDLE)
      else $error("sweep overrun");
`endif
endmodule

// ===== design/flcp_seq.sv =====
// Command sequencer: pixel, line stepper, circle stepper, clear and read.
module flcp_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [2:0]            cmd,
   input  logic [6:0]            sx,
   input  logic [5:0]            sy,
   input  logic [6:0]            ex,
   input  logic [5:0]            ey,
   input  logic [5:0]            radius,
   input  logic                  paint,
   output flcp_pkg::pix_req_type pix_req,
   output logic                  clear_req,
   output logic                  read_req,
   input  flcp_pkg::pix_sts_type sts,
   input  logic [7:0]            rd_data,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_read_data,
   output logic                  rsp_done_res
);
   import flcp_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LINE   = 3'd1;
   localparam logic [2:0] S_CIRC   = 3'd2;
   localparam logic [2:0] S_CSTEP  = 3'd3;
   localparam logic [2:0] S_WAIT   = 3'd4;
   localparam logic [2:0] S_RDWAIT = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic        paint_ff, paint_in;
   // Coordinates kept as signed 10-bit values so circle points may fall off screen.
   logic signed [9:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [9:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [6:0]  dx_ff, dx_in, dy_ff, dy_in, dist_ff, dist_in, cnt_ff, cnt_in;
   logic [7:0]  erx_ff, erx_in, ery_ff, ery_in;
   logic        nx_ff, nx_in, ny_ff, ny_in;
   logic [6:0]  a_ff, a_in, b_ff, b_in;
   logic [2:0]  oct_ff, oct_in;
   logic [11:0] rr_ff, rr_in;
   logic [12:0] aabb;
   logic        rsp_v_ff, rsp_v_in;
   logic [7:0]  rsp_d_ff, rsp_d_in;
   logic        rsp_r_ff, rsp_r_in;
   logic signed [9:0] px, py;
   logic [7:0]  erx_n, ery_n;
   logic [6:0]  a1;

   // Octant point offsets, one per cycle while the store is not busy.
   always_comb begin
      case (oct_ff)
         3'd0: begin px = ox_ff + 10'(a_ff); py = oy_ff - 10'(b_ff); end
         3'd1: begin px = ox_ff - 10'(a_ff); py = oy_ff - 10'(b_ff); end
         3'd2: begin px = ox_ff - 10'(a_ff); py = oy_ff + 10'(b_ff); end
         3'd3: begin px = ox_ff + 10'(a_ff); py = oy_ff + 10'(b_ff); end
         3'd4: begin px = ox_ff + 10'(b_ff); py = oy_ff + 10'(a_ff); end
         3'd5: begin px = ox_ff + 10'(b_ff); py = oy_ff - 10'(a_ff); end
         3'd6: begin px = ox_ff - 10'(b_ff); py = oy_ff - 10'(a_ff); end
         default: begin px = ox_ff - 10'(b_ff); py = oy_ff + 10'(a_ff); end
      endcase
   end

   assign a1   = a_ff + 7'd1;
   assign aabb = 13'(a1 * a1) + 13'(b_ff * b_ff);
   assign erx_n = erx_ff + 8'(dx_ff);
   assign ery_n = ery_ff + 8'(dy_ff);

   always_comb begin
      state_in  = state_ff;
      paint_in  = paint_ff;
      cx_in = cx_ff; cy_in = cy_ff; ox_in = ox_ff; oy_in = oy_ff;
      dx_in = dx_ff; dy_in = dy_ff; dist_in = dist_ff; cnt_in = cnt_ff;
      erx_in = erx_ff; ery_in = ery_ff; nx_in = nx_ff; ny_in = ny_ff;
      a_in = a_ff; b_in = b_ff; oct_in = oct_ff; rr_in = rr_ff;
      rsp_v_in = 1'b0; rsp_d_in = 8'd0; rsp_r_in = 1'b0;
      pix_req = '0;
      clear_req = 1'b0;
      read_req  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start && !sts.busy) begin
               paint_in = paint;
               case (cmd)
                  CMD_PIXEL: begin
                     pix_req.valid = 1'b1;
                     pix_req.paint = paint;
                     pix_req.x = 10'(sx);
                     pix_req.y = 10'(sy);
                     state_in = S_WAIT;
                  end
                  CMD_LINE: begin
                     cx_in = 10'(sx); cy_in = 10'(sy);
                     nx_in = ex < sx; ny_in = ey < sy;
                     dx_in = (ex < sx) ? sx - ex : ex - sx;
                     dy_in = (ey < sy) ? 7'(sy - ey) : 7'(ey - sy);
                     dist_in = (dx_in > dy_in) ? dx_in : dy_in;
                     erx_in = '0; ery_in = '0; cnt_in = '0;
                     state_in = S_LINE;
                  end
                  CMD_CIRCLE: begin
                     ox_in = 10'(sx); oy_in = 10'(sy);
                     a_in = '0; b_in = 7'(radius); oct_in = '0;
                     rr_in = 12'(radius) * 12'(radius);
                     if (radius == 6'd0) begin
                        pix_req.valid = 1'b1;
                        pix_req.paint = 1'b1;
                        pix_req.x = 10'(sx);
                        pix_req.y = 10'(sy);
                        state_in = S_WAIT;
                     end else begin
                        state_in = S_CIRC;
                     end
                  end
                  CMD_CLEAR: begin
                     clear_req = 1'b1;
                     state_in = S_WAIT;
                  end
                  CMD_READ: begin
                     pix_req.valid = 1'b1;
                     pix_req.x = 10'(sx);
                     pix_req.y = 10'(sy);
                     read_req = 1'b1;
                     state_in = S_RDWAIT;
                  end
                  default: begin
                     rsp_v_in = 1'b1;
                  end
               endcase
            end
         end
         S_LINE: begin
            if (!sts.busy) begin
               pix_req.valid = 1'b1;
               pix_req.paint = paint_ff;
               pix_req.x = cx_ff;
               pix_req.y = cy_ff;
               if (erx_n > 8'(dist_ff)) begin
                  erx_in = erx_n - 8'(dist_ff);
                  cx_in = nx_ff ? cx_ff - 10'sd1 : cx_ff + 10'sd1;
               end else erx_in = erx_n;
               if (ery_n > 8'(dist_ff)) begin
                  ery_in = ery_n - 8'(dist_ff);
                  cy_in = ny_ff ? cy_ff - 10'sd1 : cy_ff + 10'sd1;
               end else ery_in = ery_n;
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff == dist_ff) state_in = S_WAIT;
            end
         end
         S_CIRC: begin
            if (!sts.busy) begin
               pix_req.valid = 1'b1;
               pix_req.paint = 1'b1;
               pix_req.x = px;
               pix_req.y = py;
               oct_in = oct_ff + 3'd1;
               if (oct_ff == 3'd7) state_in = S_CSTEP;
            end
         end
         S_CSTEP: begin
            if (aabb > 13'(rr_ff)) begin
               b_in = b_ff - 7'd1;
               if (13'(b_in * b_in) << 1 >= 13'(rr_ff)) state_in = S_CIRC;
               else state_in = S_WAIT;
            end else begin
               a_in = a1;
               state_in = S_CIRC;
            end
         end
         S_WAIT: begin
            if (!sts.busy) begin
               rsp_v_in = 1'b1;
               rsp_r_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RDWAIT: begin
            if (sts.rd_valid) begin
               rsp_v_in = 1'b1;
               rsp_r_in = 1'b1;
               rsp_d_in = rd_data;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_v_ff <= rsp_v_in;
      end
      paint_ff <= paint_in;
      cx_ff <= cx_in; cy_ff <= cy_in; ox_ff <= ox_in; oy_ff <= oy_in;
      dx_ff <= dx_in; dy_ff <= dy_in; dist_ff <= dist_in; cnt_ff <= cnt_in;
      erx_ff <= erx_in; ery_ff <= ery_in; nx_ff <= nx_in; ny_ff <= ny_in;
      a_ff <= a_in; b_ff <= b_in; oct_ff <= oct_in; rr_ff <= rr_in;
      rsp_d_ff <= rsp_d_in;
      rsp_r_ff <= rsp_r_in;
   end

   assign busy          = (state_ff != S_IDLE) || sts.busy;
   assign rsp_valid     = rsp_v_ff;
   assign rsp_read_data = rsp_d_ff;
   assign rsp_done_res  = rsp_r_ff;

`ifndef NO_ASSERTIONS
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> state_ff == S_IDLE) else $error("response outside idle");
   a_rd_src: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_d_ff != 8'd0 |-> $past(state_ff) == S_RDWAIT)
      else $error("data on non-read");
   a_circ_oct: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CSTEP |-> $past(oct_ff) == 3'd7) else $error("octant skip");
`endif
endmodule

// ===== dv/framebuffer_line_circle_plotter_tb.sv =====
// Self-checking testbench for the frame-buffer line and circle plotter.
`timescale 1ns / 100ps

module framebuffer_line_circle_plotter_tb;
   import flcp_pkg::*;

   localparam int WIDTH     = 128;
   localparam int PAGES     = 8;
   localparam int HEIGHT    = PAGES * 8;
   localparam int IDLE_LIMIT = 20000;
   localparam logic [2:0] CMD_BAD_LO = 3'd5;
   localparam logic [2:0] CMD_BAD_HI = 3'd7;

   typedef struct packed {
      logic [7:0] read_data;
      logic       done_res;
   } plot_result_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [2:0] req_cmd;
   logic [6:0] req_start_x;
   logic [5:0] req_start_y;
   logic [6:0] req_end_x;
   logic [5:0] req_end_y;
   logic [5:0] req_radius;
   logic       req_paint;
   logic       rsp_valid;
   logic [7:0] rsp_read_data;
   logic       rsp_done_res;

   logic [7:0]      shadow_frame [WIDTH*PAGES];
   plot_result_type pending_results [$];
   int              error_count;
   int              idle_cycles;
   int              reads_checked;
   int              cmds_sent;
   int              burst_left;

   framebuffer_line_circle_plotter dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y), .req_radius(req_radius),
      .req_paint(req_paint), .rsp_valid(rsp_valid), .rsp_read_data(rsp_read_data),
      .rsp_done_res(rsp_done_res)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void shadow_plot(int x, int y, bit paint);
      int idx;
      if (x < 0 || y < 0 || x >= WIDTH || y >= HEIGHT) return;
      idx = (y / 8) * WIDTH + x;
      if (paint) shadow_frame[idx][y % 8] = 1'b1;
      else shadow_frame[idx][y % 8] = 1'b0;
   endfunction

   function automatic void shadow_line(int x0, int y0, int x1, int y1, bit paint);
      int dx, dy, sx, sy, span, ex, ey, cx, cy;
      dx = x1 - x0; dy = y1 - y0; sx = 0; sy = 0; ex = 0; ey = 0;
      cx = x0; cy = y0;
      if (dx > 0) sx = 1;
      else if (dx < 0) begin sx = -1; dx = -dx; end
      if (dy > 0) sy = 1;
      else if (dy < 0) begin sy = -1; dy = -dy; end
      span = (dx > dy) ? dx : dy;
      for (int i = 0; i <= span; i++) begin
         shadow_plot(cx, cy, paint);
         ex += dx; ey += dy;
         if (ex > span) begin ex -= span; cx += sx; end
         if (ey > span) begin ey -= span; cy += sy; end
      end
   endfunction

   function automatic void shadow_circle(int x, int y, int r);
      int a, b;
      a = 0; b = r;
      if (r == 0) begin
         shadow_plot(x, y, 1'b1);
         return;
      end
      while (2 * b * b >= r * r) begin
         shadow_plot(x + a, y - b, 1'b1);
         shadow_plot(x - a, y - b, 1'b1);
         shadow_plot(x - a, y + b, 1'b1);
         shadow_plot(x + a, y + b, 1'b1);
         shadow_plot(x + b, y + a, 1'b1);
         shadow_plot(x + b, y - a, 1'b1);
         shadow_plot(x - b, y - a, 1'b1);
         shadow_plot(x - b, y + a, 1'b1);
         a++;
         if (a * a + b * b - r * r > 0) begin b--; a--; end
      end
   endfunction

   // Updates the shadow frame and returns what the block should answer.
   function automatic plot_result_type predict_plot(logic [2:0] cmd, int sx, int sy,
                                                    int ex, int ey, int r, bit paint);
      plot_result_type res;
      res.read_data = 8'h00;
      res.done_res  = 1'b1;
      case (cmd)
         CMD_PIXEL:  shadow_plot(sx, sy, paint);
         CMD_LINE:   shadow_line(sx, sy, ex, ey, paint);
         CMD_CIRCLE: shadow_circle(sx, sy, r);
         CMD_CLEAR:  foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
         CMD_READ: begin
            if (sx < WIDTH && sy / 8 < PAGES) res.read_data = shadow_frame[(sy / 8) * WIDTH + sx];
         end
         default: res.done_res = 1'b0;
      endcase
      return res;
   endfunction

   // Random bursts, with a gap ahead of each burst.
   task automatic send_cmd(logic [2:0] cmd, logic [6:0] sx, logic [5:0] sy,
                           logic [6:0] ex, logic [5:0] ey, logic [5:0] r, logic paint);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      start       <= 1'b1;
      req_cmd     <= cmd;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x   <= ex;
      req_end_y   <= ey;
      req_radius  <= r;
      req_paint   <= paint;
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_plot(cmd, sx, sy, ex, ey, r, paint));
      if (cmd == CMD_READ) reads_checked++;
      cmds_sent++;
   endtask

   task automatic read_byte(logic [6:0] col, logic [5:0] y);
      send_cmd(CMD_READ, col, y, 7'($urandom), 6'($urandom), 6'($urandom), 1'($urandom));
   endtask

   task automatic test_directed();
      send_cmd(CMD_PIXEL, 7'd0, 6'd0, 7'd0, 6'd0, 6'd0, 1'b1);
      send_cmd(CMD_PIXEL, 7'd127, 6'd63, 7'd0, 6'd0, 6'd0, 1'b1);
      read_byte(7'd0, 6'd0);
      read_byte(7'd127, 6'd63);
      send_cmd(CMD_PIXEL, 7'd127, 6'd63, 7'd0, 6'd0, 6'd0, 1'b0);
      read_byte(7'd127, 6'd56);
      send_cmd(CMD_LINE, 7'd0, 6'd0, 7'd127, 6'd63, 6'd0, 1'b1);
      send_cmd(CMD_LINE, 7'd127, 6'd0, 7'd0, 6'd63, 6'd0, 1'b1);
      send_cmd(CMD_LINE, 7'd10, 6'd20, 7'd10, 6'd20, 6'd0, 1'b1);
      send_cmd(CMD_LINE, 7'd5, 6'd60, 7'd5, 6'd2, 6'd0, 1'b0);
      read_byte(7'd5, 6'd8);
      // Circles whose outlines together run off every edge of the screen, then radius 0 and 1.
      send_cmd(CMD_CIRCLE, 7'd2, 6'd3, 7'd0, 6'd0, 6'd63, 1'b0);
      send_cmd(CMD_CIRCLE, 7'd127, 6'd63, 7'd0, 6'd0, 6'd40, 1'b1);
      send_cmd(CMD_CIRCLE, 7'd64, 6'd32, 7'd0, 6'd0, 6'd0, 1'b0);
      send_cmd(CMD_CIRCLE, 7'd64, 6'd32, 7'd0, 6'd0, 6'd1, 1'b0);
      read_byte(7'd64, 6'd32);
      read_byte(7'd65, 6'd32);
      send_cmd(CMD_BAD_LO, 7'd1, 6'd1, 7'd1, 6'd1, 6'd1, 1'b1);
      send_cmd(CMD_BAD_HI, 7'd127, 6'd63, 7'd127, 6'd63, 6'd63, 1'b1);
      send_cmd(CMD_CLEAR, 7'd0, 6'd0, 7'd0, 6'd0, 6'd0, 1'b0);
      read_byte(7'd0, 6'd0);
      read_byte(7'd64, 6'd32);
   endtask

   task automatic test_random(int count);
      logic [2:0] cmd;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) cmd = CMD_PIXEL;
         else if (pick < 45) cmd = CMD_LINE;
         else if (pick < 57) cmd = CMD_CIRCLE;
         else if (pick < 59) cmd = CMD_CLEAR;
         else if (pick < 95) cmd = CMD_READ;
         else cmd = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
         // Circles are slow, so most of them are small.
         send_cmd(cmd, 7'($urandom), 6'($urandom), 7'($urandom), 6'($urandom),
                  ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12)),
                  1'($urandom));
      end
   endtask

   task automatic test_readback();
      for (int p = 0; p < PAGES; p++) read_byte(7'($urandom), 6'(p * 8 + $urandom_range(0, 7)));
   endtask

   // Every result is taken on the edge that ends its strobe cycle.
   always @(posedge clock) begin
      plot_result_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $error("result with no transaction pending: read_data %0h done_res %0b",
                      rsp_read_data, rsp_done_res);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data expected %0h actual %0h", want.read_data, rsp_read_data);
                  error_count++;
               end
               if (rsp_done_res !== want.done_res) begin
                  $error("done_res expected %0b actual %0b", want.done_res, rsp_done_res);
                  error_count++;
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      error_count = 0; cmds_sent = 0; reads_checked = 0; burst_left = 0;
      foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      reset = 1'b1; start = 1'b0; req_cmd = CMD_PIXEL;
      req_start_x = '0; req_start_y = '0; req_end_x = '0; req_end_y = '0;
      req_radius = '0; req_paint = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(420);
      test_readback();
      start <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (50) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         error_count++;
      end
      $display("Covered %0d commands: pixels, lines, clipped circles, clears, bad codes,",
               cmds_sent);
      $display("with %0d byte reads checked against the shadow frame.", reads_checked);
      if (error_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
